### rtl/core/pressure_temp_humidity_compensation_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef PRESSURE_TEMP_HUMIDITY_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMP_HUMIDITY_COMPENSATION_MACROS_SVH

// same-cycle implication
`define PTC_ASSERT_IMPL(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication
`define PTC_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

### rtl/core/ptc_pkg.sv
package ptc_pkg;

    localparam int RAW_W      = 24;
    localparam int CHK_W      = 8;
    localparam int COEF_W     = 16;
    localparam int NUM_COEF   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int TEMP_W     = 19;
    localparam int PRES_W     = 32;
    localparam int HUM_W      = 15;
    localparam int PHASE_W    = 2;

    localparam int TEMP_REF    = 2000;
    localparam int TEMP_LOW    = -1500;
    localparam int OFF2_K      = 61;
    localparam int SENS2_K     = 29;
    localparam int OFF3_K      = 17;
    localparam int SENS3_K     = 9;
    localparam int T2_LO_K     = 3;
    localparam int T2_HI_K     = 5;
    localparam int T2_LO_SHIFT = 33;
    localparam int T2_HI_SHIFT = 38;
    localparam int HUM_SCALE   = 12500;
    localparam int HUM_OFFSET  = -600;
    localparam int HELD_UNSET  = -100;
    localparam logic [7:0] CRC_POLY = 8'h31;

    typedef logic [COEF_W-1:0] coef_t;
    typedef coef_t [NUM_COEF-1:0] coef_arr_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C1 = 3'd0,
        CFG_C2 = 3'd1,
        CFG_C3 = 3'd2,
        CFG_C4 = 3'd3,
        CFG_C5 = 3'd4,
        CFG_C6 = 3'd5
    } cfg_idx_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_PRESSURE = 2'd0,
        PH_TEMP     = 2'd1,
        PH_HUM      = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DT,
        OP_TEMP,
        OP_SQ,
        OP_LO,
        OP_VL,
        OP_OFF,
        OP_SENS,
        OP_PLO,
        OP_PHI,
        OP_PRES,
        OP_CRC_HI,
        OP_CRC_LO,
        OP_HUM
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DT,
        ST_TEMP,
        ST_SQ,
        ST_LO,
        ST_VL,
        ST_OFF,
        ST_SENS,
        ST_PLO,
        ST_PHI,
        ST_PRES,
        ST_CRC_HI,
        ST_CRC_LO,
        ST_HUM,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               crc_ok;
    } dp_stat_t;

    // msb-first crc-8 over one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

### rtl/core/ptc_ctrl.sv
module ptc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_free,
    input  ptc_pkg::dp_stat_t stat,
    output ptc_pkg::dp_cmd_t  cmd
);
    import ptc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_ready && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (stat.phase)
                        PH_PRESSURE: state_next = ST_DONE;
                        PH_TEMP:     state_next = ST_DT;
                        default:     state_next = ST_CRC_HI;
                    endcase
                end
            end
            ST_DT:     state_next = ST_TEMP;
            ST_TEMP:   state_next = ST_SQ;
            ST_SQ:     state_next = ST_LO;
            ST_LO:     state_next = ST_VL;
            ST_VL:     state_next = ST_OFF;
            ST_OFF:    state_next = ST_SENS;
            ST_SENS:   state_next = ST_PLO;
            ST_PLO:    state_next = ST_PHI;
            ST_PHI:    state_next = ST_PRES;
            ST_PRES:   state_next = ST_DONE;
            ST_CRC_HI: state_next = ST_CRC_LO;
            ST_CRC_LO: state_next = ST_HUM;
            ST_HUM:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        cmd.emit = 1'b0;
        case (state_reg)
            ST_IDLE:   cmd.op = accept ? OP_LOAD : OP_NONE;
            ST_DT:     cmd.op = OP_DT;
            ST_TEMP:   cmd.op = OP_TEMP;
            ST_SQ:     cmd.op = OP_SQ;
            ST_LO:     cmd.op = OP_LO;
            ST_VL:     cmd.op = OP_VL;
            ST_OFF:    cmd.op = OP_OFF;
            ST_SENS:   cmd.op = OP_SENS;
            ST_PLO:    cmd.op = OP_PLO;
            ST_PHI:    cmd.op = OP_PHI;
            ST_PRES:   cmd.op = OP_PRES;
            ST_CRC_HI: cmd.op = OP_CRC_HI;
            ST_CRC_LO: cmd.op = OP_CRC_LO;
            ST_HUM:    cmd.op = stat.crc_ok ? OP_HUM : OP_NONE;
            ST_DONE:   cmd.emit = out_free;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

### rtl/core/ptc_dp.sv
module ptc_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ptc_pkg::dp_cmd_t                  cmd,
    input  ptc_pkg::coef_arr_t                coef,
    input  logic [ptc_pkg::RAW_W-1:0]         in_raw,
    input  logic [ptc_pkg::CHK_W-1:0]         in_check,
    output ptc_pkg::dp_stat_t                 stat,
    output logic signed [ptc_pkg::TEMP_W-1:0] held_temp,
    output logic signed [ptc_pkg::PRES_W-1:0] held_pres,
    output logic signed [ptc_pkg::HUM_W-1:0]  held_hum,
    output logic [ptc_pkg::PHASE_W-1:0]       taken,
    output logic                              status
);
    import ptc_pkg::*;

    logic [RAW_W-1:0]          raw_reg;
    logic [CHK_W-1:0]          chk_reg;
    logic [RAW_W-1:0]          pressure_raw_reg;
    phase_t                    phase_reg;
    logic [PHASE_W-1:0]        taken_reg;
    logic                      status_reg;
    logic [7:0]                crc_reg;
    logic signed [24:0]        dt_reg;
    logic signed [19:0]        temp_reg;
    logic [49:0]               sq_reg;
    logic [19:0]               t2_reg;
    logic [47:0]               off2_reg;
    logic [47:0]               sens2_reg;
    logic signed [47:0]        off_reg;
    logic signed [47:0]        sens_reg;
    logic [63:0]               acc_reg;
    logic signed [TEMP_W-1:0]  held_temp_reg;
    logic signed [PRES_W-1:0]  held_pres_reg;
    logic signed [HUM_W-1:0]   held_hum_reg;

    logic signed [25:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [51:0] mul_p;
    logic signed [20:0] tdiff;
    logic signed [20:0] tsum;
    logic [53:0]        sq_lo;
    logic [53:0]        sq_hi;
    logic [47:0]        sqr;
    logic [7:0]         crc_fin;
    logic signed [63:0] acc_sh;
    logic signed [63:0] pres_full;
    logic               temp_low;
    logic               temp_vlow;

    assign tdiff     = 21'(temp_reg) - 21'(TEMP_REF);
    assign tsum      = 21'(temp_reg) - 21'(TEMP_LOW);
    assign temp_low  = temp_reg < 20'(TEMP_REF);
    assign temp_vlow = temp_reg < 20'(TEMP_LOW);
    assign sqr       = 48'(mul_p);
    assign sq_lo     = 54'(sq_reg) * 54'(T2_LO_K);
    assign sq_hi     = 54'(sq_reg) * 54'(T2_HI_K);
    assign crc_fin   = crc8_byte(crc_reg, raw_reg[7:0]);
    assign acc_sh    = $signed(acc_reg) >>> 21;
    assign pres_full = acc_sh - 64'(off_reg);

    // one shared multiplier, operands picked by the current step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_TEMP:
            begin
                mul_a = 26'(dt_reg);
                mul_b = $signed({10'b0, coef[CFG_C6]});
            end
            OP_SQ:
            begin
                mul_a = 26'(dt_reg);
                mul_b = 26'(dt_reg);
            end
            OP_LO:
            begin
                mul_a = 26'(tdiff);
                mul_b = 26'(tdiff);
            end
            OP_VL:
            begin
                mul_a = 26'(tsum);
                mul_b = 26'(tsum);
            end
            OP_OFF:
            begin
                mul_a = 26'(dt_reg);
                mul_b = $signed({10'b0, coef[CFG_C4]});
            end
            OP_SENS:
            begin
                mul_a = 26'(dt_reg);
                mul_b = $signed({10'b0, coef[CFG_C3]});
            end
            OP_PLO:
            begin
                mul_a = $signed({2'b0, pressure_raw_reg});
                mul_b = $signed({2'b0, sens_reg[23:0]});
            end
            OP_PHI:
            begin
                mul_a = $signed({2'b0, pressure_raw_reg});
                mul_b = 26'($signed(sens_reg[47:24]));
            end
            OP_HUM:
            begin
                mul_a = $signed({10'b0, raw_reg[15:0]});
                mul_b = 26'(HUM_SCALE);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // model state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PRESSURE;
            pressure_raw_reg <= '0;
            status_reg       <= 1'b0;
            taken_reg        <= '0;
            held_temp_reg    <= '0;
            held_pres_reg    <= PRES_W'(HELD_UNSET);
            held_hum_reg     <= HUM_W'(HELD_UNSET);
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    taken_reg  <= phase_reg;
                    status_reg <= 1'b0;
                    if (phase_reg == PH_PRESSURE)
                    begin
                        pressure_raw_reg <= in_raw;
                        phase_reg        <= PH_TEMP;
                    end
                end
                OP_PRES:
                begin
                    held_temp_reg <= TEMP_W'(temp_reg - $signed({1'b0, t2_reg}));
                    held_pres_reg <= pres_full[46:15];
                    phase_reg     <= PH_HUM;
                end
                OP_CRC_LO:
                begin
                    status_reg <= (crc_fin != chk_reg);
                end
                OP_HUM:
                begin
                    held_hum_reg <= $signed({1'b0, mul_p[29:16]}) + HUM_W'(HUM_OFFSET);
                    phase_reg    <= PH_PRESSURE;
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                raw_reg <= in_raw;
                chk_reg <= in_check;
            end
            OP_DT:
            begin
                dt_reg <= $signed({1'b0, raw_reg}) - $signed({1'b0, coef[CFG_C5], 8'b0});
            end
            OP_TEMP:
            begin
                temp_reg <= 20'(mul_p >>> 23) + 20'(TEMP_REF);
            end
            OP_SQ:
            begin
                sq_reg <= mul_p[49:0];
            end
            OP_LO:
            begin
                if (temp_low)
                begin
                    t2_reg    <= 20'(sq_lo >> T2_LO_SHIFT);
                    off2_reg  <= (sqr * 48'(OFF2_K)) >> 4;
                    sens2_reg <= (sqr * 48'(SENS2_K)) >> 4;
                end
                else
                begin
                    t2_reg    <= 20'(sq_hi >> T2_HI_SHIFT);
                    off2_reg  <= '0;
                    sens2_reg <= '0;
                end
            end
            OP_VL:
            begin
                if (temp_vlow)
                begin
                    off2_reg  <= off2_reg + sqr * 48'(OFF3_K);
                    sens2_reg <= sens2_reg + sqr * 48'(SENS3_K);
                end
            end
            OP_OFF:
            begin
                off_reg <= $signed({15'b0, coef[CFG_C2], 17'b0}) + 48'(mul_p >>> 6)
                           - $signed(off2_reg);
            end
            OP_SENS:
            begin
                sens_reg <= $signed({16'b0, coef[CFG_C1], 16'b0}) + 48'(mul_p >>> 7)
                            - $signed(sens2_reg);
            end
            OP_PLO:
            begin
                acc_reg <= {12'b0, mul_p};
            end
            OP_PHI:
            begin
                // upper partial product, wraps at 64 bits
                acc_reg <= acc_reg + {mul_p[39:0], 24'b0};
            end
            OP_CRC_HI:
            begin
                crc_reg <= crc8_byte(8'h00, raw_reg[15:8]);
            end
            default:
            begin
            end
        endcase
    end

    assign stat.phase  = phase_reg;
    assign stat.crc_ok = !status_reg;
    assign held_temp   = held_temp_reg;
    assign held_pres   = held_pres_reg;
    assign held_hum    = held_hum_reg;
    assign taken       = taken_reg;
    assign status      = status_reg;

endmodule

### rtl/core/pressure_temp_humidity_compensation.sv
// Second-order barometric compensation with humidity. Input words arrive in a fixed
// rotation: raw pressure, raw temperature, then the humidity word with its crc-8 byte
// (poly 0x31, init 0); a failed check reports status 1 and keeps the humidity phase.
// Every input word returns one result word carrying the held temperature, pressure and
// humidity in hundredths. A pressure word goes straight to the result, while a
// temperature word steps eight products through one shared 26x26 multiplier under the
// sequencer and the humidity path runs the crc a byte per cycle. One result word waits
// in the output register; a new input word is taken while it waits. Coefficients C1..C6
// are written at cfg_index 0..5; the user must do so only while idle (not enforced).
module pressure_temp_humidity_compensation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // raw_value[23:0], check_byte[31:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // temperature[18:0], pressure[50:19], humidity[65:51]
    output logic [2:0]  m_axis_tuser,   // phase_taken[1:0], status[2]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptc_pkg::COEF_W-1:0]    cfg_data
);
    import ptc_pkg::*;

    `include "pressure_temp_humidity_compensation_macros.svh"

    coef_arr_t                coef_reg;
    dp_cmd_t                  cmd;
    dp_stat_t                 stat;
    logic                     out_free;
    logic                     m_valid_reg;
    logic signed [TEMP_W-1:0] held_temp;
    logic signed [PRES_W-1:0] held_pres;
    logic signed [HUM_W-1:0]  held_hum;
    logic [PHASE_W-1:0]       taken;
    logic                     status;
    logic [71:0]              m_data_reg;
    logic [2:0]               m_user_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_COEF)))
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    ptc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    ptc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .coef      (coef_reg),
        .in_raw    (s_axis_tdata[23:0]),
        .in_check  (s_axis_tdata[31:24]),
        .stat      (stat),
        .held_temp (held_temp),
        .held_pres (held_pres),
        .held_hum  (held_hum),
        .taken     (taken),
        .status    (status)
    );

    assign out_free = !m_valid_reg || m_axis_tready;

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_data_reg <= {6'b0, held_hum, held_pres, held_temp};
            m_user_reg <= {status, taken};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    `PTC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input accepted while an item was still in flight")
    `PTC_ASSERT_IMPL(a_emit_slot_free, cmd.emit, !m_valid_reg || m_axis_tready,
        "result written over an unread output word")
    `PTC_ASSERT_IMPL(a_status_humidity, m_axis_tvalid && m_axis_tuser[2],
        m_axis_tuser[1:0] == PH_HUM, "crc error flagged outside the humidity phase")

endmodule
